@@ rtl/jmsp_pkg.sv @@
package jmsp_pkg;

	localparam int NumJointsDef = 6;
	localparam int MaxJoints    = 8;
	localparam int AngW         = 18;
	localparam int MagW         = 19;
	localparam int SpdW         = 16;
	localparam int JsW          = 15;
	localparam int RailW        = 17;
	localparam int StampW       = 32;
	// quotient width: gain*mag fits in 41 bits, quotient in 41
	localparam int NumW         = 41;
	localparam int DivW         = 32;

	localparam logic [1:0] CMD_MOVE  = 2'd0;
	localparam logic [1:0] CMD_SERVO = 2'd1;
	localparam logic [1:0] CMD_FB    = 2'd2;
	localparam logic [1:0] CMD_RSVD  = 2'd3;

	localparam logic [SpdW-1:0] SPEED_FLOOR = 16'd13;
	localparam logic [SpdW-1:0] SERVO_CAP   = 16'd51200;
	localparam logic [20:0]     SERVO_GAIN  = 21'd1500000;
	localparam logic [StampW-1:0] SERVO_MIN_US = 32'd1000;
	localparam logic [StampW-1:0] SERVO_DEF_US = 32'd20000;
	localparam logic signed [AngW-1:0] RAIL_LIM = 18'sd64000;

	function automatic logic signed [AngW-1:0] lim_lo(input int k);
		case (k)
			0: lim_lo = -18'sd44800;
			1: lim_lo = -18'sd19200;
			2: lim_lo = 18'sd0;
			3: lim_lo = -18'sd69120;
			4: lim_lo = -18'sd25600;
			default: lim_lo = -18'sd46080;
		endcase
	endfunction

	function automatic logic signed [AngW-1:0] lim_hi(input int k);
		case (k)
			0: lim_hi = 18'sd44800;
			1: lim_hi = 18'sd23040;
			2: lim_hi = 18'sd46080;
			3: lim_hi = 18'sd69120;
			4: lim_hi = 18'sd25600;
			default: lim_hi = 18'sd46080;
		endcase
	endfunction

endpackage

@@ rtl/joint_move_speed_planner.sv @@
// Joint speed planner: feedback items (cmd 2) update the measured angles and give
// no result; move (cmd 0) and servo (cmd 1) items are limit checked and give one
// result. One item at a time: a rejected item goes straight to the hold state and
// waits there for the output register. A planned item is accepted, the largest
// delta is found over the joints, then per joint a shift-and-add product is formed
// (one multiplier bit a cycle), a restoring division runs (one quotient bit a
// cycle) and the speed is stored; last the result is moved to the output
// register. The bit-serial multiplier and divider are shared by all joints. Results
// wait in their own output register, so a new item can be taken while a result is
// stalled; a finished item waits only until the previous result has left.
module joint_move_speed_planner
	import jmsp_pkg::*;
#(
	parameter int NUM_JOINTS = NumJointsDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [JsW-1:0] cfg_wdata,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] cmd,
	input  logic signed [AngW-1:0] angle_j1,
	input  logic signed [AngW-1:0] angle_j2,
	input  logic signed [AngW-1:0] angle_j3,
	input  logic signed [AngW-1:0] angle_j4,
	input  logic signed [AngW-1:0] angle_j5,
	input  logic signed [AngW-1:0] angle_j6,
	input  logic signed [AngW-1:0] rail_pos,
	input  logic [StampW-1:0] now_us,
	output logic out_valid,
	input  logic out_stall,
	output logic status,
	output logic [SpdW-1:0] speed_j1,
	output logic [SpdW-1:0] speed_j2,
	output logic [SpdW-1:0] speed_j3,
	output logic [SpdW-1:0] speed_j4,
	output logic [SpdW-1:0] speed_j5,
	output logic [SpdW-1:0] speed_j6,
	output logic signed [RailW-1:0] rail_target
);

	localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
	localparam int MulCnt = 21;
	localparam int DivCnt = NumW;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_OUT  = 3'd3;
	localparam logic [2:0] ST_MAG  = 3'd4;
	localparam logic [2:0] ST_HOLD = 3'd5;

	logic [2:0] state_q;
	logic [JsW-1:0] jspeed_q;
	logic signed [AngW-1:0] meas_q [NUM_JOINTS];
	logic [MagW-1:0] mag_q [NUM_JOINTS];
	logic [SpdW-1:0] spd_q [NUM_JOINTS];
	logic [SpdW-1:0] out_spd_q [NUM_JOINTS];
	logic [MagW-1:0] maxd_q;
	logic signed [RailW-1:0] rail_goal_q;
	logic signed [RailW-1:0] out_rail_q;
	logic [StampW-1:0] stamp_q;
	logic [StampW-1:0] dt_q;
	logic servo_q;
	logic status_q;
	logic out_status_q;
	logic ovalid_q;
	logic [JW-1:0] jidx_q;
	logic [5:0] cnt_q;
	logic [20:0] mcand_q;
	logic [NumW-1:0] acc_q;
	logic [NumW-1:0] quo_q;
	logic [DivW:0] rem_q;
	logic [DivW-1:0] dvs_q;

	logic signed [AngW-1:0] ang [NUM_JOINTS];
	logic ok;
	logic accept;
	logic load;
	logic [DivW:0] rem_sh;
	logic [DivW:0] rem_sub;
	logic [SpdW-1:0] spd_res;
	logic [StampW-1:0] dt_raw;

	// pack joint angles; joints beyond six reuse joint six
	always_comb begin
		for (int j = 0; j < NUM_JOINTS; j++) begin
			case (j)
				0: ang[j] = angle_j1;
				1: ang[j] = angle_j2;
				2: ang[j] = angle_j3;
				3: ang[j] = angle_j4;
				4: ang[j] = angle_j5;
				default: ang[j] = angle_j6;
			endcase
		end
	end

	// limit check
	always_comb begin
		ok = (rail_pos <= RAIL_LIM) && (rail_pos >= -RAIL_LIM);
		for (int j = 0; j < NUM_JOINTS; j++) begin
			if (ang[j] > lim_hi(j % MaxJoints) || ang[j] < lim_lo(j % MaxJoints))
				ok = 1'b0;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign load = (state_q == ST_HOLD) && (!ovalid_q || !out_stall);
	assign dt_raw = now_us - stamp_q;

	// divider step
	assign rem_sh = {rem_q[DivW-1:0], acc_q[NumW-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	// final speed of one joint from the quotient
	always_comb begin
		if (servo_q) begin
			spd_res = (quo_q > NumW'(SERVO_CAP)) ? SERVO_CAP : quo_q[SpdW-1:0];
		end else if (maxd_q == '0) begin
			spd_res = '0;
		end else begin
			spd_res = quo_q[SpdW-1:0];
		end
		if (spd_res < SPEED_FLOOR)
			spd_res = SPEED_FLOOR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			jspeed_q <= '0;
			rail_goal_q <= '0;
			out_rail_q <= '0;
			stamp_q <= '0;
			dt_q <= '0;
			ovalid_q <= 1'b0;
			servo_q <= 1'b0;
			status_q <= 1'b0;
			out_status_q <= 1'b0;
			maxd_q <= '0;
			jidx_q <= '0;
			cnt_q <= '0;
			mcand_q <= '0;
			acc_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			dvs_q <= '0;
			for (int j = 0; j < NUM_JOINTS; j++) begin
				meas_q[j] <= '0;
				mag_q[j] <= '0;
				spd_q[j] <= '0;
				out_spd_q[j] <= '0;
			end
		end else begin
			if (cfg_we)
				jspeed_q <= cfg_wdata;
			// output register: load a finished item or drop the departing one
			if (load)
				ovalid_q <= 1'b1;
			else if (!out_stall)
				ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd == CMD_FB) begin
							for (int j = 0; j < NUM_JOINTS; j++)
								meas_q[j] <= ang[j];
						end else if (cmd == CMD_MOVE || cmd == CMD_SERVO) begin
							servo_q <= (cmd == CMD_SERVO);
							if (!ok) begin
								status_q <= 1'b1;
								for (int j = 0; j < NUM_JOINTS; j++)
									spd_q[j] <= '0;
								state_q <= ST_HOLD;
							end else begin
								status_q <= 1'b0;
								dt_q <= (dt_raw <= SERVO_MIN_US) ? SERVO_DEF_US : dt_raw;
								if (cmd == CMD_SERVO)
									stamp_q <= now_us;
								rail_goal_q <= rail_pos[RailW-1:0];
								// magnitudes; measured angles kept for the compare
								for (int j = 0; j < NUM_JOINTS; j++) begin
									mag_q[j] <= ((ang[j] - meas_q[j]) < 0) ?
										MagW'(meas_q[j] - ang[j]) :
										MagW'(ang[j] - meas_q[j]);
								end
								jidx_q <= '0;
								maxd_q <= '0;
								state_q <= ST_MAG;
							end
						end
					end
				end
				// running maximum, one joint a cycle
				ST_MAG: begin
					if (mag_q[jidx_q] > maxd_q)
						maxd_q <= mag_q[jidx_q];
					if (int'(jidx_q) == NUM_JOINTS - 1) begin
						jidx_q <= '0;
						acc_q <= '0;
						cnt_q <= '0;
						state_q <= ST_MUL;
					end else begin
						jidx_q <= jidx_q + 1'b1;
					end
				end
				// shift-and-add product mag * (gain or joint_speed)
				ST_MUL: begin
					if (cnt_q == '0) begin
						mcand_q <= servo_q ? SERVO_GAIN : 21'(jspeed_q);
						acc_q <= '0;
						cnt_q <= 6'd1;
					end else begin
						if (mcand_q[20])
							acc_q <= (acc_q << 1) + NumW'(mag_q[jidx_q]);
						else
							acc_q <= acc_q << 1;
						mcand_q <= mcand_q << 1;
						if (cnt_q == 6'(MulCnt)) begin
							cnt_q <= '0;
							rem_q <= '0;
							quo_q <= '0;
							dvs_q <= servo_q ? dt_q : DivW'(maxd_q);
							state_q <= ST_DIV;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				// restoring division, one quotient bit a cycle
				ST_DIV: begin
					acc_q <= acc_q << 1;
					if (!rem_sub[DivW]) begin
						rem_q <= rem_sub;
						quo_q <= {quo_q[NumW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[NumW-2:0], 1'b0};
					end
					if (cnt_q == 6'(DivCnt - 1))
						state_q <= ST_OUT;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				ST_OUT: begin
					spd_q[jidx_q] <= spd_res;
					cnt_q <= '0;
					if (int'(jidx_q) == NUM_JOINTS - 1) begin
						state_q <= ST_HOLD;
					end else begin
						jidx_q <= jidx_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				// wait for the output register to be free
				ST_HOLD: begin
					if (load) begin
						out_status_q <= status_q;
						out_rail_q <= rail_goal_q;
						for (int j = 0; j < NUM_JOINTS; j++)
							out_spd_q[j] <= spd_q[j];
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign status = out_status_q;
	assign rail_target = out_rail_q;
	assign speed_j1 = out_spd_q[0];
	assign speed_j2 = (NUM_JOINTS > 1) ? out_spd_q[(NUM_JOINTS > 1) ? 1 : 0] : '0;
	assign speed_j3 = (NUM_JOINTS > 2) ? out_spd_q[(NUM_JOINTS > 2) ? 2 : 0] : '0;
	assign speed_j4 = (NUM_JOINTS > 3) ? out_spd_q[(NUM_JOINTS > 3) ? 3 : 0] : '0;
	assign speed_j5 = (NUM_JOINTS > 4) ? out_spd_q[(NUM_JOINTS > 4) ? 4 : 0] : '0;
	assign speed_j6 = (NUM_JOINTS > 5) ? out_spd_q[(NUM_JOINTS > 5) ? 5 : 0] : '0;

endmodule
